// File: sv/adll_pkg.sv
package adll_pkg;
    localparam int SLOTS = 16;
    localparam int SW = 4;
    localparam int LW = 5;
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    localparam logic [2:0] M_ADD_FIRST = 3'd0;
    localparam logic [2:0] M_ADD_AFTER = 3'd1;
    localparam logic [2:0] M_ADD_LAST  = 3'd2;
    localparam logic [2:0] M_DEL_FIRST = 3'd3;
    localparam logic [2:0] M_DEL_AFTER = 3'd4;
    localparam logic [2:0] M_DEL_LAST  = 3'd5;
    localparam logic [2:0] M_CLEAR     = 3'd6;
    localparam logic [2:0] M_SEARCH    = 3'd7;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_NOTFND  = 3'd3;
    localparam logic [2:0] ST_NOSUCC  = 3'd4;
    localparam logic [2:0] ST_BADSLOT = 3'd5;

    typedef struct packed {
        logic           load;     // latch request
        logic           rd;       // read entry at rd_addr
        logic [LW-1:0]  rd_addr;
        logic           ins;      // link new entry
        logic           del;      // unlink entry r_rd_slot
        logic           clr;
        logic           hit;      // record search hit from read data
        logic [2:0]     status;
    } t_cmd;

    typedef struct packed {
        logic [2:0]    mode;
        logic          full;
        logic          ref_ok;
        logic          empty;
        logic [LW-1:0] head;
        logic [LW-1:0] tail;
        logic [SW-1:0] slot;
        logic [LW-1:0] rd_next;
        logic          key_eq;
    } t_stat;
endpackage

// File: sv/array_doubly_linked_list_engine_top.sv
// Array doubly linked list engine.
// Slave channel: one transaction per operation, tdata = {value, key, slot, mode}.
// Master channel: one transaction per operation,
//   tdata = {entry_count, found_value, result_slot, status}.
// Adds, clear and errors caught at decode end in the decode state;
// delete first/last reads the entry, then unlinks it; delete after
// reads the reference entry, then unlinks its successor or ends with
// a missing successor. A search visits at most SLOTS entries, reading
// one entry per cycle from the link store. One operation is worked at
// a time; the next is accepted in the cycle after the result is registered.
// The result sits in an output register; the next operation is accepted
// while it waits, but its own result is held back until the receiver
// takes the earlier one, so a stall simply pauses the engine.
// Reset (synchronous, active low) empties the list: all slots free,
// count zero; stored keys, values and links keep stale contents.
module array_doubly_linked_list_engine_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // mode[2:0], slot[6:3], key[70:7], value[102:71]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata    // status[2:0], result_slot[6:3], found_value[38:7],
                                    // entry_count[43:39]
);
    import adll_pkg::*;

    adll_pkg::t_cmd  cmd;
    adll_pkg::t_stat stat;
    logic idle, done, busy;
    logic [3:0]  rslot;
    logic [31:0] found;
    logic [4:0]  cnt;
    logic [47:0] r_out;
    logic        r_ov;

    assign busy = r_ov && !m_tready;
    assign s_tready = idle;

    adll_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(s_tvalid && s_tready),
        .i_out_busy(busy), .i_stat(stat),
        .o_cmd(cmd), .o_idle(idle), .o_done(done)
    );

    adll_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_mode(s_tdata[2:0]), .i_slot(s_tdata[6:3]), .i_key(s_tdata[70:7]),
        .i_value(s_tdata[102:71]), .o_rslot(rslot), .o_found(found), .o_count(cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (done) begin
            r_ov <= 1'b1;
        end else if (m_tready) begin
            r_ov <= 1'b0;
        end
        if (done) begin
            r_out <= {4'd0, cnt,
                      (cmd.status == ST_OK) ? found : 32'd0,
                      (cmd.status == ST_OK) ? rslot : 4'd0,
                      cmd.status};
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_out;
endmodule

// File: sv/adll_datapath.sv
module adll_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  adll_pkg::t_cmd         i_cmd,
    output adll_pkg::t_stat        o_stat,
    input  logic [2:0]             i_mode,
    input  logic [3:0]             i_slot,
    input  logic [63:0]            i_key,
    input  logic [31:0]            i_value,
    output logic [3:0]             o_rslot,
    output logic [31:0]            o_found,
    output logic [4:0]             o_count
);
    import adll_pkg::*;

    logic [63:0]   r_key_mem [SLOTS];
    logic [31:0]   r_val_mem [SLOTS];
    logic [LW-1:0] r_next [SLOTS];
    logic [LW-1:0] r_prev [SLOTS];
    logic [SLOTS-1:0] r_used;
    logic [LW-1:0] r_head, r_tail;
    logic [4:0]    r_count;
    logic [2:0]    r_mode;
    logic [SW-1:0] r_slot;
    logic [63:0]   r_key;
    logic [31:0]   r_value;
    logic [63:0]   r_rd_key;
    logic [LW-1:0] r_rd_next;
    logic [SW-1:0] r_rd_slot;
    logic [SW-1:0] r_rslot;
    logic [31:0]   r_found;

    logic [LW-1:0] free_slot;
    logic [SW-1:0] fs;
    logic [LW-1:0] ins_ref, succ, dp, dq;

    always_comb begin
        free_slot = NIL;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) free_slot = LW'(i);
        end
        fs = free_slot[SW-1:0];
        case (r_mode)
            M_ADD_FIRST: ins_ref = NIL;
            M_ADD_AFTER: ins_ref = {1'b0, r_slot};
            default:     ins_ref = r_tail;
        endcase
        succ = (ins_ref == NIL) ? r_head : r_next[ins_ref[SW-1:0]];
        dp = r_prev[r_rd_slot];
        dq = r_next[r_rd_slot];
    end

    assign o_stat.mode    = r_mode;
    assign o_stat.full    = free_slot == NIL;
    assign o_stat.ref_ok  = r_used[r_slot];
    assign o_stat.empty   = r_head == NIL;
    assign o_stat.head    = r_head;
    assign o_stat.tail    = r_tail;
    assign o_stat.slot    = r_slot;
    assign o_stat.rd_next = r_rd_next;
    assign o_stat.key_eq  = r_rd_key == r_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode; r_slot <= i_slot; r_key <= i_key; r_value <= i_value;
            r_rslot <= '0; r_found <= '0;
        end
        if (i_cmd.rd) begin
            r_rd_slot <= i_cmd.rd_addr[SW-1:0];
            r_rd_key  <= r_key_mem[i_cmd.rd_addr[SW-1:0]];
            r_rd_next <= r_next[i_cmd.rd_addr[SW-1:0]];
        end
        if (i_cmd.hit) begin
            r_rslot <= r_rd_slot;
            r_found <= r_val_mem[r_rd_slot];
        end
        if (i_cmd.ins) begin
            r_key_mem[fs] <= r_key;
            r_val_mem[fs] <= r_value;
            r_prev[fs] <= ins_ref;
            r_next[fs] <= succ;
            if (ins_ref != NIL) r_next[ins_ref[SW-1:0]] <= {1'b0, fs};
            if (succ != NIL) r_prev[succ[SW-1:0]] <= {1'b0, fs};
            r_rslot <= fs;
        end
        if (i_cmd.del) begin
            if (dp != NIL) r_next[dp[SW-1:0]] <= dq;
            if (dq != NIL) r_prev[dq[SW-1:0]] <= dp;
            r_rslot <= r_rd_slot;
        end
        if (!i_rst_n) begin
            r_used <= '0; r_head <= NIL; r_tail <= NIL; r_count <= '0;
        end else if (i_cmd.clr) begin
            r_used <= '0; r_head <= NIL; r_tail <= NIL; r_count <= '0;
        end else if (i_cmd.ins) begin
            r_used[fs] <= 1'b1;
            r_count <= r_count + 5'd1;
            if (ins_ref == NIL) r_head <= {1'b0, fs};
            if (succ == NIL) r_tail <= {1'b0, fs};
        end else if (i_cmd.del) begin
            r_used[r_rd_slot] <= 1'b0;
            r_count <= r_count - 5'd1;
            if (dp == NIL) r_head <= dq;
            if (dq == NIL) r_tail <= dp;
        end
    end

    assign o_rslot = r_rslot;
    assign o_found = r_found;
    assign o_count = r_count;
endmodule

// File: sv/adll_ctrl.sv
module adll_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_busy,
    input  adll_pkg::t_stat  i_stat,
    output adll_pkg::t_cmd   o_cmd,
    output logic             o_idle,
    output logic             o_done
);
    import adll_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_DEL  = 3'd2;
    localparam logic [2:0] S_DA   = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_status, n_status;
    logic [LW-1:0] r_steps, n_steps;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_status = r_status;
        n_steps = r_steps;
        o_cmd.rd_addr = '0;
        case (r_state)
            S_IDLE: if (i_in_fire) begin
                o_cmd.load = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                n_status = ST_OK;
                n_state = S_DONE;
                case (i_stat.mode)
                    M_ADD_FIRST, M_ADD_LAST, M_ADD_AFTER: begin
                        if (i_stat.full) n_status = ST_FULL;
                        else if (i_stat.mode == M_ADD_AFTER && !i_stat.ref_ok)
                            n_status = ST_BADSLOT;
                        else o_cmd.ins = 1'b1;
                    end
                    M_DEL_FIRST, M_DEL_LAST: begin
                        if (i_stat.empty) n_status = ST_EMPTY;
                        else begin
                            o_cmd.rd = 1'b1;
                            o_cmd.rd_addr = (i_stat.mode == M_DEL_FIRST)
                                ? i_stat.head : i_stat.tail;
                            n_state = S_DEL;
                        end
                    end
                    M_DEL_AFTER: begin
                        if (!i_stat.ref_ok) n_status = ST_BADSLOT;
                        else begin
                            o_cmd.rd = 1'b1;
                            o_cmd.rd_addr = {1'b0, i_stat.slot};
                            n_state = S_DA;
                        end
                    end
                    M_CLEAR: o_cmd.clr = 1'b1;
                    default: begin
                        if (i_stat.empty) n_status = ST_EMPTY;
                        else begin
                            o_cmd.rd = 1'b1;
                            o_cmd.rd_addr = i_stat.head;
                            n_steps = '0;
                            n_status = ST_NOTFND;
                            n_state = S_WALK;
                        end
                    end
                endcase
            end
            S_DA: begin
                if (i_stat.rd_next == NIL) begin
                    n_status = ST_NOSUCC;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_addr = i_stat.rd_next;
                    n_state = S_DEL;
                end
            end
            S_DEL: begin
                o_cmd.del = 1'b1;
                n_state = S_DONE;
            end
            S_WALK: begin
                if (i_stat.key_eq) begin
                    o_cmd.hit = 1'b1;
                    n_status = ST_OK;
                    n_state = S_DONE;
                end else if (i_stat.rd_next == NIL || r_steps == LW'(SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_addr = i_stat.rd_next;
                    n_steps = r_steps + LW'(1);
                end
            end
            S_DONE: if (!i_out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        o_cmd.status = r_status;
    end

    assign o_idle = r_state == S_IDLE;
    assign o_done = r_state == S_DONE && !i_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_status <= ST_OK; r_steps <= '0;
        end else begin
            r_state <= n_state; r_status <= n_status; r_steps <= n_steps;
        end
    end
endmodule
